[src/nns_pkg.sv]
// Shared constants, types and codes of the nearest-neighbor scaler.
`timescale 1ns / 1ps
package nns_pkg;
  localparam int POS_W      = 12;
  localparam int SRC_W      = 9;
  localparam int DST_W      = 13;
  localparam int PIX_W      = 32;
  localparam int ST_W       = 2;
  localparam int AH_W       = 8;
  localparam int ADDR_W     = 2 * AH_W;
  localparam int MAX_SRC    = 256;
  localparam int MAX_DST    = 4096;
  localparam int Q_W        = 9;
  localparam int NUM_W      = 22;
  localparam int PROD_W     = POS_W + SRC_W;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int CNT_W      = 5;
  localparam int PADDR_W    = 4;

  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_READ  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [PADDR_W-1:0] ADR_SRC_ROWS = 4'd0;
  localparam logic [PADDR_W-1:0] ADR_SRC_COLS = 4'd4;
  localparam logic [PADDR_W-1:0] ADR_DST_ROWS = 4'd8;
  localparam logic [PADDR_W-1:0] ADR_DST_COLS = 4'd12;

  // Effective (clamped) image sizes
  typedef struct packed {
    logic [SRC_W-1:0] sr;
    logic [SRC_W-1:0] sc;
    logic [DST_W-1:0] dr;
    logic [DST_W-1:0] dc;
  } cfg_t;

  // One classified operation between front and back
  typedef struct packed {
    logic             is_read;
    logic             wr_ok;
    logic [ST_W-1:0]  status;
    logic [AH_W-1:0]  row;
    logic [AH_W-1:0]  col;
    logic [PIX_W-1:0] pix;
  } op_t;
endpackage

[src/nns_if.sv]
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
interface nns_in_if import nns_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [POS_W-1:0] pos_row;
  logic [POS_W-1:0] pos_col;
  logic [PIX_W-1:0] pixel_in;
  modport source(output valid, func, pos_row, pos_col, pixel_in, input ready);
  modport sink(input valid, func, pos_row, pos_col, pixel_in, output ready);
endinterface

interface nns_out_if import nns_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [ST_W-1:0]  status;
  modport source(output valid, pixel_out, status, input ready);
  modport sink(input valid, pixel_out, status, output ready);
endinterface

[src/nns_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[src/nns_front.sv]
// Front end: accepts words, classifies them and maps coordinates with pipelined dividers.
`timescale 1ns / 1ps
module nns_front import nns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  nns_in_if.sink           in_ch,
  input  logic [CNT_W-1:0] fifo_cnt,
  output logic             push,
  output op_t              push_op
);
  logic             v_r      [0:Q_W];
  op_t              op_r     [0:Q_W];
  logic [NUM_W-1:0] rrem_r   [0:Q_W];
  logic [NUM_W-1:0] crem_r   [0:Q_W];
  logic [Q_W-1:0]   rq_r     [0:Q_W];
  logic [Q_W-1:0]   cq_r     [0:Q_W];
  logic [NUM_W-1:0] rrem_nxt [1:Q_W];
  logic [NUM_W-1:0] crem_nxt [1:Q_W];
  logic [Q_W-1:0]   rq_nxt   [1:Q_W];
  logic [Q_W-1:0]   cq_nxt   [1:Q_W];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             acc;
  logic [PROD_W-1:0] rprod, cprod;
  op_t              cls;
  logic             empty_sz;
  logic [SRC_W-1:0] sr_m1, sc_m1;
  op_t              fin;

  // Credit check: pipeline plus queue never exceed the queue depth
  assign in_ch.ready = ({1'b0, cnt_r} + {1'b0, fifo_cnt}) < (CNT_W + 1)'(FIFO_DEPTH);
  assign acc = in_ch.valid & in_ch.ready;

  // Classify the incoming word
  assign empty_sz = (cfg.sr == '0) || (cfg.sc == '0) || (cfg.dr == '0) || (cfg.dc == '0);
  always_comb begin
    cls.is_read = (in_ch.func == FN_READ);
    cls.wr_ok   = (in_ch.pos_row < POS_W'(cfg.sr)) && (in_ch.pos_col < POS_W'(cfg.sc));
    if (empty_sz) begin
      cls.status = ST_EMPTY;
    end else if ((DST_W'(in_ch.pos_row) >= cfg.dr) ||
                 (DST_W'(in_ch.pos_col) >= cfg.dc)) begin
      cls.status = ST_RANGE;
    end else begin
      cls.status = ST_OK;
    end
    cls.row = in_ch.pos_row[AH_W-1:0];
    cls.col = in_ch.pos_col[AH_W-1:0];
    cls.pix = in_ch.pixel_in;
  end

  // Scaled position products
  assign rprod = PROD_W'(in_ch.pos_row) * PROD_W'(cfg.sr);
  assign cprod = PROD_W'(in_ch.pos_col) * PROD_W'(cfg.sc);

  // One quotient bit per stage, restoring division by 2*dest
  always_comb begin
    logic [NUM_W-1:0] rdiv;
    logic [NUM_W-1:0] cdiv;
    for (int s = 1; s <= Q_W; s++) begin
      rdiv = NUM_W'({cfg.dr, 1'b0}) << (Q_W - s);
      cdiv = NUM_W'({cfg.dc, 1'b0}) << (Q_W - s);
      if (rrem_r[s-1] >= rdiv) begin
        rrem_nxt[s] = rrem_r[s-1] - rdiv;
        rq_nxt[s]   = rq_r[s-1] | (Q_W'(1) << (Q_W - s));
      end else begin
        rrem_nxt[s] = rrem_r[s-1];
        rq_nxt[s]   = rq_r[s-1];
      end
      if (crem_r[s-1] >= cdiv) begin
        crem_nxt[s] = crem_r[s-1] - cdiv;
        cq_nxt[s]   = cq_r[s-1] | (Q_W'(1) << (Q_W - s));
      end else begin
        crem_nxt[s] = crem_r[s-1];
        cq_nxt[s]   = cq_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= Q_W; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      v_r[0] <= acc;
      for (int s = 1; s <= Q_W; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r[0]   <= cls;
    rrem_r[0] <= NUM_W'({rprod, 1'b0}) + NUM_W'(cfg.dr);
    crem_r[0] <= NUM_W'({cprod, 1'b0}) + NUM_W'(cfg.dc);
    rq_r[0]   <= '0;
    cq_r[0]   <= '0;
    for (int s = 1; s <= Q_W; s++) begin
      op_r[s]   <= op_r[s-1];
      rrem_r[s] <= rrem_nxt[s];
      crem_r[s] <= crem_nxt[s];
      rq_r[s]   <= rq_nxt[s];
      cq_r[s]   <= cq_nxt[s];
    end
  end

  // Limit to the last source row/column and hand off
  assign sr_m1 = cfg.sr - SRC_W'(1);
  assign sc_m1 = cfg.sc - SRC_W'(1);
  always_comb begin
    fin = op_r[Q_W];
    if (fin.is_read) begin
      fin.row = (rq_r[Q_W] > sr_m1) ? sr_m1[AH_W-1:0] : rq_r[Q_W][AH_W-1:0];
      fin.col = (cq_r[Q_W] > sc_m1) ? sc_m1[AH_W-1:0] : cq_r[Q_W][AH_W-1:0];
    end
  end
  assign push    = v_r[Q_W];
  assign push_op = fin;

  // Words inside the divider pipeline
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!acc && push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[src/nns_fifo.sv]
// Short show-ahead queue of classified operations.
`timescale 1ns / 1ps
module nns_fifo import nns_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  op_t              push_op,
  input  logic             pop,
  output op_t              head,
  output logic             nonempty,
  output logic [CNT_W-1:0] cnt
);
  op_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!push && pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign head     = mem_r[rptr_r];
  assign nonempty = (cnt_r != '0);
  assign cnt      = cnt_r;
endmodule

[src/nns_back.sv]
// Back end: performs pixel store writes and reads, and holds the result word.
`timescale 1ns / 1ps
module nns_back import nns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  op_t       head,
  input  logic      nonempty,
  output logic      pop,
  nns_out_if.source out_ch
);
  logic             s1_v_r;
  logic [ST_W-1:0]  s1_st_r;
  logic             s1_go;
  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [ST_W-1:0]  out_st_r;
  logic [PIX_W-1:0] rdata;
  logic             we, re;

  // Move the read stage forward when the result register frees up
  assign s1_go = s1_v_r && (!out_v_r || out_ch.ready);
  assign pop   = nonempty && (!s1_v_r || s1_go);
  assign we    = pop && !head.is_read && head.wr_ok;
  assign re    = pop && head.is_read;

  nns_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_SRC * MAX_SRC)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr ({head.row, head.col}),
    .wdata (head.pix),
    .re    (re),
    .raddr ({head.row, head.col}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (re) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      s1_st_r <= head.status;
    end
    if (s1_go) begin
      out_pix_r <= (s1_st_r == ST_OK) ? rdata : '0;
      out_st_r  <= s1_st_r;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.status    = out_st_r;
endmodule

[src/nearest_neighbor_image_scaler_core.sv]
// Top level of the nearest-neighbor image scaler with its register port.
//
// Request words come in on in_ch: func 0 stores pixel_in at source (pos_row,
// pos_col), func 1 asks for the destination pixel at (pos_row, pos_col).
// Each read gives one result word on out_ch (pixel_out, status); writes give
// none. Words are taken one per cycle while in_ch.ready is high. A read result
// passes through the input register, nine more stages of the bit-per-stage
// row/column dividers, the queue write, the registered store read and the result register.
// Sizes are set through the APB port (source rows/cols at 0x0/0x4, dest
// rows/cols at 0x8/0xC) and may only change while no word is in flight.
// Reset sets all sizes to 16 and empties the pipeline; stored pixels are
// undefined until written. When out_ch stalls, the queue fills and in_ch.ready
// drops once pipeline and queue together hold 16 words; nothing is lost.
`timescale 1ns / 1ps
module nearest_neighbor_image_scaler_core import nns_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  nns_in_if.sink             in_ch,
  nns_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [SRC_W-1:0] src_rows_r, src_cols_r;
  logic [DST_W-1:0] dst_rows_r, dst_cols_r;
  logic             wr;
  cfg_t             cfg;
  logic             push, pop, nonempty;
  op_t              push_op, head;
  logic [CNT_W-1:0] fifo_cnt;

  // Register writes
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SRC_W'(16);
      src_cols_r <= SRC_W'(16);
      dst_rows_r <= DST_W'(16);
      dst_cols_r <= DST_W'(16);
    end else if (wr) begin
      case (cfg_paddr)
        ADR_SRC_ROWS: src_rows_r <= cfg_pwdata[SRC_W-1:0];
        ADR_SRC_COLS: src_cols_r <= cfg_pwdata[SRC_W-1:0];
        ADR_DST_ROWS: dst_rows_r <= cfg_pwdata[DST_W-1:0];
        ADR_DST_COLS: dst_cols_r <= cfg_pwdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr)
      ADR_SRC_ROWS: cfg_prdata = 32'(src_rows_r);
      ADR_SRC_COLS: cfg_prdata = 32'(src_cols_r);
      ADR_DST_ROWS: cfg_prdata = 32'(dst_rows_r);
      ADR_DST_COLS: cfg_prdata = 32'(dst_cols_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Oversized settings act as the maximum
  assign cfg.sr = (src_rows_r > SRC_W'(MAX_SRC)) ? SRC_W'(MAX_SRC) : src_rows_r;
  assign cfg.sc = (src_cols_r > SRC_W'(MAX_SRC)) ? SRC_W'(MAX_SRC) : src_cols_r;
  assign cfg.dr = (dst_rows_r > DST_W'(MAX_DST)) ? DST_W'(MAX_DST) : dst_rows_r;
  assign cfg.dc = (dst_cols_r > DST_W'(MAX_DST)) ? DST_W'(MAX_DST) : dst_cols_r;

  nns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .fifo_cnt (fifo_cnt),
    .push     (push),
    .push_op  (push_op)
  );

  nns_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .cnt      (fifo_cnt)
  );

  nns_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .out_ch   (out_ch)
  );
endmodule

[bench/scaler_checker.sv]
// Checker for the nearest-neighbor scaler: predicts each result word and compares it.
`timescale 1ns / 1ps
module scaler_checker import nns_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  nns_in_if                  in_ch,
  nns_out_if                 out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 reads_checked
);
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ST_W-1:0]  st;
  } scaled_word_t;

  scaled_word_t       scaled_q[$];
  logic [PIX_W-1:0]   pixel_mem[int];
  logic [SRC_W-1:0]   rows_reg, cols_reg;
  logic [DST_W-1:0]   drows_reg, dcols_reg;

  function automatic int unsigned clamp_side(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // round(pos*src/dst) half away from zero, capped at src-1
  function automatic int unsigned nearest_src(int unsigned pos, int unsigned src,
                                              int unsigned dst);
    longint unsigned q;
    q = (2 * longint'(pos) * src + dst) / (2 * longint'(dst));
    if (q > src - 1) q = src - 1;
    return int'(q);
  endfunction

  function automatic scaled_word_t scale_read(int unsigned row, int unsigned col);
    int unsigned  sr, sc, dr, dc, key;
    scaled_word_t w;
    sr = clamp_side(rows_reg, MAX_SRC);
    sc = clamp_side(cols_reg, MAX_SRC);
    dr = clamp_side(drows_reg, MAX_DST);
    dc = clamp_side(dcols_reg, MAX_DST);
    w = '0;
    if (sr == 0 || sc == 0 || dr == 0 || dc == 0) w.st = ST_EMPTY;
    else if (row >= dr || col >= dc) w.st = ST_RANGE;
    else begin
      key = nearest_src(row, sr, dr) * MAX_SRC + nearest_src(col, sc, dc);
      w.pix = pixel_mem.exists(key) ? pixel_mem[key] : '0;
      w.st = ST_OK;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    scaled_word_t got, want;
    int unsigned  sr, sc;
    if (!rst_n) begin
      rows_reg = 16; cols_reg = 16; drows_reg = 16; dcols_reg = 16;
      scaled_q.delete();
      fail_count = 0;
      reads_checked = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADR_SRC_ROWS: rows_reg = cfg_pwdata[SRC_W-1:0];
          ADR_SRC_COLS: cols_reg = cfg_pwdata[SRC_W-1:0];
          ADR_DST_ROWS: drows_reg = cfg_pwdata[DST_W-1:0];
          ADR_DST_COLS: dcols_reg = cfg_pwdata[DST_W-1:0];
          default: ;
        endcase
      end
      // request words
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FN_WRITE) begin
          sr = clamp_side(rows_reg, MAX_SRC);
          sc = clamp_side(cols_reg, MAX_SRC);
          if (in_ch.pos_row < sr && in_ch.pos_col < sc)
            pixel_mem[in_ch.pos_row * MAX_SRC + in_ch.pos_col] = in_ch.pixel_in;
        end else begin
          scaled_q.push_back(scale_read(in_ch.pos_row, in_ch.pos_col));
        end
      end
      // result words
      if (out_ch.valid && out_ch.ready) begin
        got.pix = out_ch.pixel_out;
        got.st = out_ch.status;
        if (scaled_q.size() == 0) begin
          $error("result word with none pending: pixel_out %h status %0d", got.pix, got.st);
          fail_count++;
        end else begin
          want = scaled_q.pop_front();
          reads_checked++;
          if (got.pix !== want.pix) begin
            $error("pixel_out expected %h actual %h", want.pix, got.pix);
            fail_count++;
          end
          if (got.st !== want.st) begin
            $error("status expected %0d actual %0d", want.st, got.st);
            fail_count++;
          end
        end
      end
    end
    pending = scaled_q.size();
  end
endmodule

[bench/testbench.sv]
// Top of the scaler bench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module testbench;
  import nns_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               cfg_psel, cfg_penable, cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count, pending, reads_checked;
  int                 burst_left, stall_cycles, words_sent, phases_run;
  int unsigned        eff_sr, eff_sc, eff_dr, eff_dc;
  bit                 written[int];

  nns_in_if  in_ch();
  nns_out_if out_ch();

  nearest_neighbor_image_scaler_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  scaler_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending), .reads_checked(reads_checked)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: stall pattern cycles through four modes
  always @(posedge clk) begin
    int unsigned mode;
    mode = ($time / 512) % 4;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n)
      stall_cycles <= 0;
    else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL nearest_neighbor_image_scaler_core");
      $finish;
    end
  end

  function automatic int unsigned clamp_side(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // source coordinate a legal read lands on; keeps reads off unwritten pixels
  function automatic int unsigned land_on(int unsigned pos, int unsigned src,
                                          int unsigned dst);
    longint unsigned q;
    q = (2 * longint'(pos) * src + dst) / (2 * longint'(dst));
    return (q > src - 1) ? src - 1 : int'(q);
  endfunction

  task automatic send_word(logic fn, int unsigned row, int unsigned col,
                           logic [PIX_W-1:0] pix);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.pos_row <= row[POS_W-1:0];
    in_ch.pos_col <= col[POS_W-1:0];
    in_ch.pixel_in <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (fn == FN_WRITE && row < eff_sr && col < eff_sc) written[row * MAX_SRC + col] = 1;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_pixel(int unsigned row, int unsigned col, logic [PIX_W-1:0] pix);
    send_word(FN_WRITE, row, col, pix);
  endtask

  // read, loading the landing pixel first if it was never stored
  task automatic read_pixel(int unsigned row, int unsigned col);
    int unsigned r, c;
    if (eff_sr != 0 && eff_sc != 0 && eff_dr != 0 && eff_dc != 0 &&
        row < eff_dr && col < eff_dc) begin
      r = land_on(row, eff_sr, eff_dr);
      c = land_on(col, eff_sc, eff_dc);
      if (!written.exists(r * MAX_SRC + c)) write_pixel(r, c, $urandom());
    end
    send_word(FN_READ, row, col, $urandom());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [31:0] sr, logic [31:0] sc, logic [31:0] dr,
                           logic [31:0] dc);
    drain();
    write_reg(ADR_SRC_ROWS, sr);
    write_reg(ADR_SRC_COLS, sc);
    write_reg(ADR_DST_ROWS, dr);
    write_reg(ADR_DST_COLS, dc);
    eff_sr = clamp_side(sr[SRC_W-1:0], MAX_SRC);
    eff_sc = clamp_side(sc[SRC_W-1:0], MAX_SRC);
    eff_dr = clamp_side(dr[DST_W-1:0], MAX_DST);
    eff_dc = clamp_side(dc[DST_W-1:0], MAX_DST);
    phases_run++;
  endtask

  // random mix: mostly in-range reads, some writes, some out-of-range noise
  task automatic random_words(int count);
    int unsigned pick, row, col;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        row = (eff_sr != 0 && pick < 16) ? $urandom_range(0, eff_sr - 1) : $urandom_range(0, 4095);
        col = (eff_sc != 0 && pick < 16) ? $urandom_range(0, eff_sc - 1) : $urandom_range(0, 4095);
        write_pixel(row, col, $urandom());
      end else if (pick < 35 || eff_dr == 0 || eff_dc == 0) begin
        read_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        read_pixel($urandom_range(0, eff_dr - 1), $urandom_range(0, eff_dc - 1));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_WRITE;
    in_ch.pos_row = '0;
    in_ch.pos_col = '0;
    in_ch.pixel_in = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    burst_left = 4;
    words_sent = 0;
    phases_run = 0;
    eff_sr = 16; eff_sc = 16; eff_dr = 16; eff_dc = 16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sizes, corner pixels, ignored writes, range errors
    write_pixel(0, 0, 32'h0000_0000);
    write_pixel(15, 15, 32'hFFFF_FFFF);
    write_pixel(0, 15, 32'hA5A5_5A5A);
    write_pixel(15, 0, 32'h5A5A_A5A5);
    write_pixel(16, 0, 32'h1111_1111);
    write_pixel(0, 16, 32'h2222_2222);
    write_pixel(4095, 4095, 32'h3333_3333);
    read_pixel(0, 0);
    read_pixel(15, 15);
    read_pixel(0, 15);
    read_pixel(15, 0);
    read_pixel(16, 0);
    read_pixel(0, 16);
    read_pixel(4095, 4095);
    read_pixel(2730, 1365);

    // empty size takes precedence over range
    set_sizes(0, 16, 16, 16);
    read_pixel(0, 0);
    read_pixel(4095, 4095);
    write_pixel(0, 0, 32'hDEAD_BEEF);
    set_sizes(1, 1, 1, 1);
    write_pixel(0, 0, 32'hCAFE_F00D);
    read_pixel(0, 0);
    read_pixel(1, 0);
    read_pixel(0, 1);
    random_words(60);

    set_sizes(16, 16, 16, 16);
    random_words(150);
    set_sizes(256, 256, 4096, 4096);
    read_pixel(4095, 4095);
    read_pixel(2048, 2048);
    random_words(150);
    set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_words(120);
    set_sizes(16, 0, 16, 16);
    random_words(30);
    set_sizes(16, 16, 0, 8);
    random_words(30);
    set_sizes(16, 16, 8, 0);
    random_words(30);
    set_sizes(5, 7, 3, 11);
    random_words(150);
    set_sizes(3, 2, 13, 9);
    random_words(150);
    set_sizes(256, 200, 1, 1);
    random_words(60);
    set_sizes(16, 16, 7, 40);
    random_words(150);
    repeat (6) begin
      set_sizes($urandom_range(1, 24), $urandom_range(1, 24),
                $urandom_range(1, 64), $urandom_range(1, 64));
      random_words(130);
    end
    drain();

    $display("covered %0d request words, %0d checked results over %0d size settings",
             words_sent, reads_checked, phases_run);
    if (fail_count == 0 && pending == 0)
      $display("PASS nearest_neighbor_image_scaler_core");
    else
      $display("FAIL nearest_neighbor_image_scaler_core");
    $finish;
  end
endmodule
